FILE: design/hpt_pkg.sv
// ---------------------------------------------------------------------------
// hpt_pkg
// Shared types, widths and register layout for the homogeneous point
// transform.
// ---------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

  localparam int COORD_BITS = 32;
  localparam int COEFF_BITS = 16;
  localparam int COORD_FRAC = 16;
  localparam int LANE_BITS  = 16;
  localparam int REG_BITS   = 4 * LANE_BITS;
  localparam int ADDR_BITS  = 5;
  localparam int NUM_REGS   = 4;

  localparam int PROD_W    = COORD_BITS + COEFF_BITS;
  localparam int TRANS_W   = COEFF_BITS + COORD_FRAC;
  localparam int SUM_W     = PROD_W + 2;
  localparam int MAG_W     = SUM_W;
  localparam int DIV_STEPS = MAG_W + COORD_FRAC;
  localparam int Q_W       = COORD_BITS;
  localparam int LATENCY   = 4 + DIV_STEPS + 1;

  localparam logic [1:0] REG_ROW_X = 2'd0;
  localparam logic [1:0] REG_ROW_Y = 2'd1;
  localparam logic [1:0] REG_ROW_Z = 2'd2;
  localparam logic [1:0] REG_ROW_T = 2'd3;

  localparam logic [REG_BITS-1:0] ONE_LANE  = REG_BITS'(1) << (COEFF_BITS - 4);
  localparam logic [REG_BITS-1:0] RST_ROW_X = ONE_LANE;
  localparam logic [REG_BITS-1:0] RST_ROW_Y = ONE_LANE << LANE_BITS;
  localparam logic [REG_BITS-1:0] RST_ROW_Z = ONE_LANE << (2 * LANE_BITS);
  localparam logic [REG_BITS-1:0] RST_ROW_T = ONE_LANE << (3 * LANE_BITS);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] proj_x;
    logic signed [COORD_BITS-1:0] proj_y;
    logic signed [COORD_BITS-1:0] proj_z;
    logic                         w_was_zero;
    logic                         clipped;
  } out_word_t;

  typedef struct packed {
    logic [REG_BITS-1:0] row_x;
    logic [REG_BITS-1:0] row_y;
    logic [REG_BITS-1:0] row_z;
    logic [REG_BITS-1:0] row_t;
  } coeff_bank_t;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] num;
    logic [Q_W-1:0]   q;
    logic             ovf;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    logic             valid;
    logic             wzero;
    logic [MAG_W-1:0] den;
    div_lane_t [2:0]  lanes;
  } div_word_t;

  function automatic logic signed [COEFF_BITS-1:0] coeff_lane(
    input logic [REG_BITS-1:0] row,
    input logic [1:0]          k
  );
    coeff_lane = $signed(row[k*LANE_BITS +: COEFF_BITS]);
  endfunction

endpackage

`default_nettype wire

FILE: design/hpt_regs.sv
// ---------------------------------------------------------------------------
// hpt_regs
// Configuration register file: four 64-bit coefficient rows on an APB port.
// ---------------------------------------------------------------------------
`default_nettype none

module hpt_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [hpt_pkg::ADDR_BITS-1:0]    paddr,
  input  wire logic [hpt_pkg::REG_BITS-1:0]     pwdata,
  output logic      [hpt_pkg::REG_BITS-1:0]     prdata,
  output logic                                  pready,
  output hpt_pkg::coeff_bank_t                  bank
);

  hpt_pkg::coeff_bank_t bank_r;
  logic [1:0]           idx;
  logic                 wr;

  assign pready = 1'b1;
  assign idx    = paddr[hpt_pkg::ADDR_BITS-1:3];
  assign wr     = psel & penable & pwrite;
  assign bank   = bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r.row_x <= hpt_pkg::RST_ROW_X;
      bank_r.row_y <= hpt_pkg::RST_ROW_Y;
      bank_r.row_z <= hpt_pkg::RST_ROW_Z;
      bank_r.row_t <= hpt_pkg::RST_ROW_T;
    end else if (wr) begin
      case (idx)
        hpt_pkg::REG_ROW_X: bank_r.row_x <= pwdata;
        hpt_pkg::REG_ROW_Y: bank_r.row_y <= pwdata;
        hpt_pkg::REG_ROW_Z: bank_r.row_z <= pwdata;
        hpt_pkg::REG_ROW_T: bank_r.row_t <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      hpt_pkg::REG_ROW_X: prdata = bank_r.row_x;
      hpt_pkg::REG_ROW_Y: prdata = bank_r.row_y;
      hpt_pkg::REG_ROW_Z: prdata = bank_r.row_z;
      hpt_pkg::REG_ROW_T: prdata = bank_r.row_t;
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/hpt_mac.sv
// ---------------------------------------------------------------------------
// hpt_mac
// Matrix multiply front end: products, adder tree, sign and magnitude.
// ---------------------------------------------------------------------------
`default_nettype none

module hpt_mac (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 take,
  input  wire hpt_pkg::in_word_t    in_word,
  input  wire hpt_pkg::coeff_bank_t bank,
  output hpt_pkg::div_word_t        div_word
);

  logic signed [hpt_pkg::PROD_W-1:0]  prod_r [4][3];
  logic signed [hpt_pkg::TRANS_W-1:0] trans_r [4];
  logic signed [hpt_pkg::SUM_W-1:0]   pa_r [4];
  logic signed [hpt_pkg::SUM_W-1:0]   pb_r [4];
  logic signed [hpt_pkg::SUM_W-1:0]   sum_r [4];
  logic [2:0]                         v_r;
  hpt_pkg::div_word_t                 dw_nxt;
  hpt_pkg::div_word_t                 dw_r;
  logic [hpt_pkg::MAG_W-1:0]          mag [4];
  logic [3:0]                         sgn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], take};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      prod_r[k][0] <= hpt_pkg::PROD_W'(in_word.point_x) *
                      hpt_pkg::PROD_W'(hpt_pkg::coeff_lane(bank.row_x, 2'(k)));
      prod_r[k][1] <= hpt_pkg::PROD_W'(in_word.point_y) *
                      hpt_pkg::PROD_W'(hpt_pkg::coeff_lane(bank.row_y, 2'(k)));
      prod_r[k][2] <= hpt_pkg::PROD_W'(in_word.point_z) *
                      hpt_pkg::PROD_W'(hpt_pkg::coeff_lane(bank.row_z, 2'(k)));
      trans_r[k]   <= $signed({hpt_pkg::coeff_lane(bank.row_t, 2'(k)),
                               {hpt_pkg::COORD_FRAC{1'b0}}});
      pa_r[k]      <= hpt_pkg::SUM_W'(prod_r[k][0]) + hpt_pkg::SUM_W'(prod_r[k][1]);
      pb_r[k]      <= hpt_pkg::SUM_W'(prod_r[k][2]) + hpt_pkg::SUM_W'(trans_r[k]);
      sum_r[k]     <= pa_r[k] + pb_r[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sgn[k] = sum_r[k][hpt_pkg::SUM_W-1];
      mag[k] = sgn[k] ? (~sum_r[k]) + 1'b1 : sum_r[k];
    end
    dw_nxt.valid = v_r[2];
    dw_nxt.wzero = (sum_r[3] == '0);
    dw_nxt.den   = mag[3];
    for (int k = 0; k < 3; k++) begin
      dw_nxt.lanes[k].rem = '0;
      dw_nxt.lanes[k].num = mag[k];
      dw_nxt.lanes[k].q   = '0;
      dw_nxt.lanes[k].ovf = 1'b0;
      dw_nxt.lanes[k].neg = sgn[k] ^ sgn[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dw_r.valid <= 1'b0;
    end else begin
      dw_r <= dw_nxt;
    end
  end

  assign div_word = dw_r;

endmodule

`default_nettype wire

FILE: design/hpt_div_cell.sv
// ---------------------------------------------------------------------------
// hpt_div_cell
// One restoring division step for three lanes sharing a divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module hpt_div_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hpt_pkg::div_word_t d_in,
  output hpt_pkg::div_word_t      d_out
);

  hpt_pkg::div_word_t       d_nxt;
  hpt_pkg::div_word_t       d_r;
  logic [hpt_pkg::MAG_W:0]  trial [3];
  logic [hpt_pkg::MAG_W:0]  diff [3];
  logic [2:0]               ge;

  always_comb begin
    d_nxt = d_in;
    for (int k = 0; k < 3; k++) begin
      trial[k] = {d_in.lanes[k].rem, d_in.lanes[k].num[hpt_pkg::MAG_W-1]};
      diff[k]  = trial[k] - {1'b0, d_in.den};
      ge[k]    = (trial[k] >= {1'b0, d_in.den});
      d_nxt.lanes[k].rem = ge[k] ? diff[k][hpt_pkg::MAG_W-1:0]
                                 : trial[k][hpt_pkg::MAG_W-1:0];
      d_nxt.lanes[k].num = {d_in.lanes[k].num[hpt_pkg::MAG_W-2:0], 1'b0};
      d_nxt.lanes[k].q   = {d_in.lanes[k].q[hpt_pkg::Q_W-2:0], ge[k]};
      d_nxt.lanes[k].ovf = d_in.lanes[k].ovf | d_in.lanes[k].q[hpt_pkg::Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

`default_nettype wire

FILE: design/hpt_fmt.sv
// ---------------------------------------------------------------------------
// hpt_fmt
// Result formatting: sign, saturation, zero divisor handling.
// ---------------------------------------------------------------------------
`default_nettype none

module hpt_fmt (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hpt_pkg::div_word_t d_in,
  output logic                    out_strobe,
  output hpt_pkg::out_word_t      out_word
);

  localparam logic [hpt_pkg::Q_W-1:0] MAX_NEG = {1'b1, {(hpt_pkg::Q_W-1){1'b0}}};
  localparam logic [hpt_pkg::Q_W-1:0] MAX_POS = {1'b0, {(hpt_pkg::Q_W-1){1'b1}}};

  logic [hpt_pkg::Q_W-1:0] val [3];
  logic [2:0]              clip;
  hpt_pkg::out_word_t      ow_nxt;
  hpt_pkg::out_word_t      ow_r;
  logic                    strobe_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      clip[k] = 1'b0;
      if (d_in.wzero) begin
        val[k] = '0;
      end else if (d_in.lanes[k].neg) begin
        if (d_in.lanes[k].ovf || d_in.lanes[k].q > MAX_NEG) begin
          val[k]  = MAX_NEG;
          clip[k] = 1'b1;
        end else begin
          val[k] = (~d_in.lanes[k].q) + 1'b1;
        end
      end else begin
        if (d_in.lanes[k].ovf || d_in.lanes[k].q > MAX_POS) begin
          val[k]  = MAX_POS;
          clip[k] = 1'b1;
        end else begin
          val[k] = d_in.lanes[k].q;
        end
      end
    end
    ow_nxt.proj_x     = $signed(val[0]);
    ow_nxt.proj_y     = $signed(val[1]);
    ow_nxt.proj_z     = $signed(val[2]);
    ow_nxt.w_was_zero = d_in.wzero;
    ow_nxt.clipped    = |clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    ow_r <= ow_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_word   = ow_r;

endmodule

`default_nettype wire

FILE: design/homogeneous_point_transform.sv
// ---------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 matrix transform of a Q16.16 point with perspective divide.
//
//   channel  direction  handshake                  word
//   input    in         start / busy               in_word  (x, y, z)
//   result   out        out_strobe (one cycle)     out_word (proj, flags)
//   config   in/out     APB, 64-bit, 4 registers   row coefficients
//
// One word per cycle; busy stays low. A word passes four registered
// multiply, add and magnitude stages, a chain of 66 division cells
// (one quotient bit each), and one saturation register.
// Reset clears only the valid flags and loads the identity matrix.
// The receiver cannot stall; each result shows for exactly one cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module homogeneous_point_transform (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire hpt_pkg::in_word_t             in_word,
  output logic                               out_strobe,
  output hpt_pkg::out_word_t                 out_word,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hpt_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [hpt_pkg::REG_BITS-1:0]  pwdata,
  output logic      [hpt_pkg::REG_BITS-1:0]  prdata,
  output logic                               pready
);

  hpt_pkg::coeff_bank_t bank;
  hpt_pkg::div_word_t   chain [hpt_pkg::DIV_STEPS+1];

  assign busy = 1'b0;

  hpt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bank    (bank)
  );

  hpt_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (start & ~busy),
    .in_word  (in_word),
    .bank     (bank),
    .div_word (chain[0])
  );

  for (genvar i = 0; i < hpt_pkg::DIV_STEPS; i++) begin : g_cell
    hpt_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  hpt_fmt u_fmt (
    .clk        (clk),
    .rst_n      (rst_n),
    .d_in       (chain[hpt_pkg::DIV_STEPS]),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

FILE: design/hpt_checker.sv
// ---------------------------------------------------------------------------
// hpt_checker
// Port-level checks on the point transform, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module hpt_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_strobe,
  input wire hpt_pkg::out_word_t out_word
);

  a_no_strobe_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe straight after reset");

  a_strobe_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start & ~busy, hpt_pkg::LATENCY))
    else $error("result without a word taken");

  a_wzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.w_was_zero) |->
      (out_word.proj_x == '0 && out_word.proj_y == '0 &&
       out_word.proj_z == '0 && !out_word.clipped))
    else $error("zero divisor result not cleared");

  a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.clipped) |->
      (out_word.proj_x == 32'sh7fffffff || out_word.proj_x == 32'sh80000000 ||
       out_word.proj_y == 32'sh7fffffff || out_word.proj_y == 32'sh80000000 ||
       out_word.proj_z == 32'sh7fffffff || out_word.proj_z == 32'sh80000000))
    else $error("clip flag without a saturated coordinate");

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_word   (out_word)
);

`default_nettype wire
